/* hw/rtl/b2da_pkg.sv */
// Shared constants and helper functions for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;
  localparam int INPUT_W = 32;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] BCD_FIVE   = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_THREE  = 4'd3;

  // Number of decimal digits needed to hold any value of the given bit width.
  function automatic int dec_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  // Double dabble correction of one BCD digit before the next shift.
  function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
    return (d >= BCD_FIVE) ? d + BCD_THREE : d;
  endfunction

endpackage

/* hw/rtl/b2da_dabble.sv */
// Bit-serial double dabble unit: shifts one binary bit per cycle into a BCD register.
module b2da_dabble import b2da_pkg::*; #(
  parameter int CONV_W = 32,
  parameter int NDIG   = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [CONV_W-1:0]       bin_in,
  output logic                    busy,
  output logic                    done,
  output logic [NDIG*DIGIT_W-1:0] bcd
);

  localparam int CNT_W = $clog2(CONV_W + 1);

  logic [CONV_W-1:0]       bin;
  logic [CNT_W-1:0]        cnt;
  logic                    running;
  logic [NDIG*DIGIT_W-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = add3(bcd[i*DIGIT_W +: DIGIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(CONV_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (running) begin
      bin <= bin << 1;
      bcd <= {bcd_adj[NDIG*DIGIT_W-2:0], bin[CONV_W-1]};
    end
  end

  assign busy = running | done;

endmodule

/* hw/rtl/b2da_emit.sv */
// Digit emitter: walks the BCD digits from the top, drops leading zeros, drives the output beat.
module b2da_emit import b2da_pkg::*; #(
  parameter int NDIG = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [NDIG*DIGIT_W-1:0] bcd_in,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CHAR_W-1:0]       char_code,
  output logic                    last
);

  localparam int REM_W = $clog2(NDIG + 1);

  logic [NDIG*DIGIT_W-1:0] digits;
  logic [REM_W-1:0]        remain;
  logic                    started;
  logic [DIGIT_W-1:0]      top;
  logic                    is_last;
  logic                    skip;
  logic                    slot_free;
  logic                    send;
  logic                    advance;

  assign top       = digits[NDIG*DIGIT_W-1 -: DIGIT_W];
  assign is_last   = (remain == REM_W'(1));
  assign skip      = busy && !started && (top == '0) && !is_last;
  assign slot_free = !out_valid || !out_stall;
  assign send      = busy && !skip && slot_free;
  assign advance   = skip || send;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      started   <= 1'b0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy    <= 1'b1;
        started <= 1'b0;
        remain  <= REM_W'(NDIG);
      end else if (advance) begin
        remain <= remain - REM_W'(1);
        if (send) begin
          started <= 1'b1;
        end
        if (send && is_last) begin
          busy <= 1'b0;
        end
      end
      if (send) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits <= bcd_in;
    end else if (advance) begin
      digits <= digits << DIGIT_W;
    end
    if (send) begin
      char_code <= ASCII_ZERO + CHAR_W'(top);
      last      <= is_last;
    end
  end

endmodule

/* hw/rtl/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter.
//
//   Channel  Ports                        Direction  Beat
//   input    in_valid in_stall value      in         one binary number
//   output   out_valid out_stall          out        one ASCII digit, last on the final one
//            char_code last
//
// A number passes an accept, the double dabble shift of its CONV_W bits (one bit per cycle,
// CONV_W is VALUE_WIDTH capped at 32), a hand-off to the emitter, and then a walk over
// every decimal position from the top, leading zeros included.
// The next number is taken once the last digit sits in the output register.
// Reset is synchronous and clears only control state; no clearing pass follows.
// A stalled output holds its beat; sends wait behind it, leading-zero skips do not.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [INPUT_W-1:0] value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] char_code,
  output logic              last
);

  localparam int CONV_W = (VALUE_WIDTH > INPUT_W) ? INPUT_W : VALUE_WIDTH;
  localparam int NDIG   = dec_digits(CONV_W);

  logic                    dab_busy;
  logic                    dab_done;
  logic [NDIG*DIGIT_W-1:0] dab_bcd;
  logic                    emit_busy;
  logic                    start;

  assign in_stall = dab_busy | emit_busy;
  assign start    = in_valid & ~in_stall;

  b2da_dabble #(
    .CONV_W (CONV_W),
    .NDIG   (NDIG)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .bin_in (value[CONV_W-1:0]),
    .busy   (dab_busy),
    .done   (dab_done),
    .bcd    (dab_bcd)
  );

  b2da_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (dab_done),
    .bcd_in    (dab_bcd),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

endmodule
